### rtl/semaphore_id_table_macros.svh
// Assertion macros shared by the semaphore id table.
`ifndef SEMAPHORE_ID_TABLE_MACROS_SVH
`define SEMAPHORE_ID_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("semaphore id table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("semaphore id table: next-cycle check failed");

`endif

### rtl/sit_pkg.sv
package sit_pkg;

  localparam int ENTRIES   = 16;
  localparam int SLOT_W    = $clog2(ENTRIES);
  localparam int HANDLE_W  = 4;
  localparam int CMP_W     = (SLOT_W > HANDLE_W) ? SLOT_W : HANDLE_W;
  localparam int COUNT_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  localparam logic [2:0] ST_OPENED    = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BADHANDLE = 3'd3;
  localparam logic [2:0] ST_CLOSED    = 3'd4;
  localparam logic [2:0] ST_FREED     = 3'd5;

  typedef struct packed {
    logic                operation;
    logic [31:0]         sem_id;
    logic [31:0]         init_value;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [31:0] sem_value;
    logic [2:0]  status;
  } out_item_t;

  // Item travelling down the row of cells together with what it has found.
  typedef struct packed {
    logic                op;
    logic [31:0]         id;
    logic [31:0]         init;
    logic [HANDLE_W-1:0] handle;
    logic                found;
    logic                freed;
    logic                free_found;
    logic [SLOT_W-1:0]   free_slot;
    logic [SLOT_W-1:0]   hit_slot;
    logic [31:0]         hit_value;
  } tok_t;

  // Entry creation, broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       id;
    logic [31:0]       value;
  } wr_t;

endpackage

### rtl/sit_cell.sv
module sit_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sit_pkg::SLOT_W-1:0] cell_idx,
  input  logic                      tok_in_act,
  input  sit_pkg::tok_t             tok_in,
  input  sit_pkg::wr_t              wr,
  output logic                      tok_out_act,
  output sit_pkg::tok_t             tok_out,
  output logic                      entry_valid
);
  import sit_pkg::*;

  logic               valid_r, valid_nxt;
  logic [31:0]        id_r, id_nxt;
  logic [31:0]        value_r, value_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               act_r;
  tok_t               tok_r, tok_nxt;
  logic               handle_hit;

  assign handle_hit = (CMP_W'(tok_in.handle) == CMP_W'(cell_idx));

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    value_nxt = value_r;
    count_nxt = count_r;
    tok_nxt   = tok_in;
    if (tok_in_act && tok_in.op == OP_OPEN) begin
      if (!tok_in.found && valid_r && id_r == tok_in.id) begin
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
        tok_nxt.found     = 1'b1;
        tok_nxt.hit_slot  = cell_idx;
        tok_nxt.hit_value = value_r;
      end else if (!tok_in.free_found && !valid_r) begin
        tok_nxt.free_found = 1'b1;
        tok_nxt.free_slot  = cell_idx;
      end
    end else if (tok_in_act && tok_in.op == OP_CLOSE && handle_hit && valid_r) begin
      tok_nxt.found = 1'b1;
      if (count_r <= COUNT_W'(1)) begin
        valid_nxt     = 1'b0;
        count_nxt     = '0;
        tok_nxt.freed = 1'b1;
      end else begin
        count_nxt = count_r - 1'b1;
      end
    end
    if (wr.en && wr.slot == cell_idx) begin
      valid_nxt = 1'b1;
      id_nxt    = wr.id;
      value_nxt = wr.value;
      count_nxt = COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      act_r   <= tok_in_act;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    value_r <= value_nxt;
    count_r <= count_nxt;
    tok_r   <= tok_nxt;
  end

  assign tok_out_act = act_r;
  assign tok_out     = tok_r;
  assign entry_valid = valid_r;

endmodule

### rtl/semaphore_id_table.sv
// Channel | Ports                          | Item
// input   | in_valid, in_stall, in_item    | operation, sem_id, init_value, handle
// output  | out_valid, out_stall, out_item | slot, sem_value, status
//
// Each table entry lives in one cell; an item walks the row one cell per cycle.
// An item is registered in each cell in turn, then in pend_item_r and then out_item_r.
// One item is in the table at a time; the next is taken while a result waits on out_stall.
// Reset clears every entry's valid bit at once, so items are taken right after reset.
module semaphore_id_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sit_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sit_pkg::out_item_t out_item
);
  import sit_pkg::*;
  `include "semaphore_id_table_macros.svh"

  logic [ENTRIES:0]   chain_act;
  tok_t               chain_tok [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;
  wr_t                wr;
  tok_t               last;
  out_item_t          res;
  logic               accept;
  logic               out_load;
  logic               busy_r, busy_nxt;
  logic               pend_r, pend_nxt;
  out_item_t          pend_item_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;

  always_comb begin
    chain_tok[0]            = '0;
    chain_tok[0].op         = in_item.operation;
    chain_tok[0].id         = in_item.sem_id;
    chain_tok[0].init       = in_item.init_value;
    chain_tok[0].handle     = in_item.handle;
  end
  assign chain_act[0] = accept;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sit_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (SLOT_W'(g)),
      .tok_in_act  (chain_act[g]),
      .tok_in      (chain_tok[g]),
      .wr          (wr),
      .tok_out_act (chain_act[g+1]),
      .tok_out     (chain_tok[g+1]),
      .entry_valid (valid_vec[g])
    );
  end

  assign last = chain_tok[ENTRIES];

  always_comb begin
    wr       = '0;
    wr.slot  = last.free_slot;
    wr.id    = last.id;
    wr.value = last.init;
    res      = '0;
    if (last.op == OP_OPEN) begin
      if (last.found) begin
        res.slot      = 4'(last.hit_slot);
        res.sem_value = last.hit_value;
        res.status    = ST_OPENED;
      end else if (last.free_found) begin
        wr.en         = chain_act[ENTRIES];
        res.slot      = 4'(last.free_slot);
        res.sem_value = last.init;
        res.status    = ST_CREATED;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      res.slot = 4'(last.handle);
      if (!last.found) begin
        res.status = ST_BADHANDLE;
      end else if (last.freed) begin
        res.status = ST_FREED;
      end else begin
        res.status = ST_CLOSED;
      end
    end
  end

  assign out_load = pend_r && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      pend_nxt      = 1'b0;
      busy_nxt      = 1'b0;
    end
    if (chain_act[ENTRIES]) begin
      pend_nxt = 1'b1;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_act[ENTRIES]) begin
      pend_item_r <= res;
    end
    if (out_load) begin
      out_item_r <= pend_item_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SIT_ASSERT_NOW(a_single_item, clk, rst_n, 1'b1, $countones(chain_act) <= 1)
  `SIT_ASSERT_NOW(a_arrive_busy, clk, rst_n, chain_act[ENTRIES], busy_r && !pend_r)
  `SIT_ASSERT_NOW(a_create_free, clk, rst_n, wr.en, !valid_vec[wr.slot])
  `SIT_ASSERT_NEXT(a_create_done, clk, rst_n, wr.en, valid_vec[$past(wr.slot)] && pend_r)

endmodule
